// ----- src/tbp_pkg.sv -----
// Package for the tournament branch predictor: table sizes, register codes,
// reset values and the small helper functions used by the predictor RTL.
// No dependencies; compile first.
`default_nettype none

package tbp_pkg;

    // Table geometry
    localparam int MAX_GLOBAL_BITS = 12;
    localparam int MAX_LOCAL_BITS  = 12;
    localparam int MAX_PC_BITS     = 12;

    localparam int GHIST_W = MAX_GLOBAL_BITS;
    localparam int LHIST_W = MAX_LOCAL_BITS;
    localparam int PC_W    = MAX_PC_BITS;

    localparam int GDEPTH = 1 << GHIST_W;
    localparam int LDEPTH = 1 << LHIST_W;
    localparam int PDEPTH = 1 << PC_W;

    // Clear sweep covers the largest table
    localparam int CLR_W_GL = (GHIST_W > LHIST_W) ? GHIST_W : LHIST_W;
    localparam int CLR_W    = (CLR_W_GL > PC_W) ? CLR_W_GL : PC_W;

    // Payload widths
    localparam int BPC_W = 32;
    localparam int CTR_W = 2;
    localparam int GC_W  = 2 * CTR_W;   // {chooser, global counter}

    // Configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int MASK_W    = CLR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GHB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LHB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCB = 2'd2;

    localparam logic [CFG_W-1:0] GHB_RST = 4'd9;
    localparam logic [CFG_W-1:0] LHB_RST = 4'd10;
    localparam logic [CFG_W-1:0] PCB_RST = 4'd10;

    // Table reset contents
    localparam logic [CTR_W-1:0]   CTR_RST  = 2'd1;  // weakly not taken
    localparam logic [CTR_W-1:0]   CH_RST   = 2'd2;  // weakly select global
    localparam logic [GC_W-1:0]    GC_RST   = {CH_RST, CTR_RST};
    localparam logic [LHIST_W-1:0] LH_RST   = '0;
    localparam logic [CTR_W-1:0]   CTR_MAX  = 2'd3;
    localparam logic [CTR_W-1:0]   CTR_MIN  = 2'd0;
    localparam logic [CTR_W-1:0]   CTR_HALF = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR   = 4'b0001,
        S_IDLE    = 4'b0010,
        S_LHIST   = 4'b0100,
        S_RESOLVE = 4'b1000
    } t_state;

    // Low-bit mask for a width register, saturated to its limit
    function automatic logic [MASK_W-1:0] f_mask(input logic [CFG_W-1:0] bits,
                                                 input logic [CFG_W:0]   limit);
        logic [CFG_W:0]    b;
        logic [MASK_W:0]   m;
        b = ({1'b0, bits} > limit) ? limit : {1'b0, bits};
        m = ({{MASK_W{1'b0}}, 1'b1} << b) - {{MASK_W{1'b0}}, 1'b1};
        return m[MASK_W-1:0];
    endfunction

    // Saturating 2-bit counter step
    function automatic logic [CTR_W-1:0] f_bump(input logic [CTR_W-1:0] ctr,
                                                input logic             up);
        logic [CTR_W-1:0] r;
        if (up) begin
            r = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
        end else begin
            r = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/tbp_req_if.sv -----
// Request channel of the branch predictor: valid/ready plus branch event.
// Depends on tbp_pkg.
`default_nettype none

interface tbp_req_if;
    import tbp_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [BPC_W-1:0] branch_pc;
    logic             taken;

    modport source (output valid, func, branch_pc, taken, input ready);
    modport sink   (input valid, func, branch_pc, taken, output ready);
endinterface

`default_nettype wire

// ----- src/tbp_rsp_if.sv -----
// Response channel of the branch predictor: valid/ready plus prediction.
// No package dependency.
`default_nettype none

interface tbp_rsp_if;
    logic valid;
    logic ready;
    logic predict_taken;
    logic chose_global;

    modport source (output valid, predict_taken, chose_global, input ready);
    modport sink   (input valid, predict_taken, chose_global, output ready);
endinterface

`default_nettype wire

// ----- src/tbp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ----- src/tournament_branch_predictor.sv -----
// Tournament branch predictor: global, local and chooser tables held in RAMs.
// Steps per request: local history and global/chooser read at accept, then
// local counter read, then resolve, result register and write back. One
// request in flight; resolve waits while the previous response is unread.
// Reset: clear pass over all tables, requests held off meanwhile;
// configuration writes are taken at any time.
`default_nettype none

module tournament_branch_predictor (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    tbp_req_if.sink                              i_req,
    tbp_rsp_if.source                            o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [tbp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tbp_pkg::CFG_W-1:0]       i_cfg_data
);
    import tbp_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] r_ghb, r_lhb, r_pcb;

    // Control state
    t_state             r_state, n_state;
    logic [CLR_W-1:0]   r_clr_addr;
    logic [GHIST_W-1:0] r_ghist;
    logic               r_out_valid;

    // Request payload held for the duration of the request
    logic               r_func;
    logic               r_taken;
    logic [PC_W-1:0]    r_pidx;
    logic [GHIST_W-1:0] r_gidx;
    logic               r_pred;
    logic               r_chose;

    // Masks
    logic [MASK_W-1:0]  gmask_w, lmask_w, pmask_w;
    logic [GHIST_W-1:0] gmask;
    logic [LHIST_W-1:0] lmask;
    logic [PC_W-1:0]    pmask;

    // RAM ports
    logic               gc_we, gc_re, lc_we, lc_re, lh_we, lh_re;
    logic [GHIST_W-1:0] gc_waddr, gc_raddr;
    logic [LHIST_W-1:0] lc_waddr, lc_raddr;
    logic [PC_W-1:0]    lh_waddr, lh_raddr;
    logic [GC_W-1:0]    gc_wdata, gc_rdata;
    logic [CTR_W-1:0]   lc_wdata, lc_rdata;
    logic [LHIST_W-1:0] lh_wdata, lh_rdata;

    // Resolve-stage logic
    logic               req_fire, resolve_fire, clearing, clr_last;
    logic [CTR_W-1:0]   gctr, cctr, gctr_n, cctr_n, lctr_n;
    logic               gdir, ldir, use_global, pred;
    logic [LHIST_W-1:0] lidx, lhist_n;
    logic [GHIST_W-1:0] ghist_n;

    assign gmask_w = f_mask(r_ghb, (CFG_W+1)'(MAX_GLOBAL_BITS));
    assign lmask_w = f_mask(r_lhb, (CFG_W+1)'(MAX_LOCAL_BITS));
    assign pmask_w = f_mask(r_pcb, (CFG_W+1)'(MAX_PC_BITS));
    assign gmask   = gmask_w[GHIST_W-1:0];
    assign lmask   = lmask_w[LHIST_W-1:0];
    assign pmask   = pmask_w[PC_W-1:0];

    // Handshakes
    assign i_req.ready  = (r_state == S_IDLE);
    assign req_fire     = i_req.valid && (r_state == S_IDLE);
    assign resolve_fire = (r_state == S_RESOLVE) && (!r_out_valid || o_rsp.ready);
    assign clearing     = (r_state == S_CLEAR);
    assign clr_last     = &r_clr_addr;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.predict_taken = r_pred;
    assign o_rsp.chose_global  = r_chose;

    // Prediction from the read data
    assign lidx       = lh_rdata & lmask;
    assign gctr       = gc_rdata[CTR_W-1:0];
    assign cctr       = gc_rdata[GC_W-1:CTR_W];
    assign gdir       = (gctr >= CTR_HALF);
    assign ldir       = (lc_rdata >= CTR_HALF);
    assign use_global = (cctr >= CTR_HALF);
    assign pred       = use_global ? gdir : ldir;

    // Training updates
    assign cctr_n  = (gdir != ldir) ? f_bump(cctr, gdir == r_taken) : cctr;
    assign gctr_n  = f_bump(gctr, r_taken);
    assign lctr_n  = f_bump(lc_rdata, r_taken);
    assign ghist_n = {r_ghist[GHIST_W-2:0], r_taken} & gmask;
    assign lhist_n = {lh_rdata[LHIST_W-2:0], r_taken} & lmask;

    // Read side: history and global/chooser at accept, local counter next
    assign gc_re    = req_fire;
    assign gc_raddr = r_ghist & gmask;
    assign lh_re    = req_fire;
    assign lh_raddr = i_req.branch_pc[PC_W-1:0] & pmask;
    assign lc_re    = (r_state == S_LHIST);
    assign lc_raddr = lidx;

    // Write side: clear sweep, else training write-back
    always_comb begin
        if (clearing) begin
            gc_we    = ((r_clr_addr >> GHIST_W) == '0);
            lc_we    = ((r_clr_addr >> LHIST_W) == '0);
            lh_we    = ((r_clr_addr >> PC_W) == '0);
            gc_waddr = r_clr_addr[GHIST_W-1:0];
            lc_waddr = r_clr_addr[LHIST_W-1:0];
            lh_waddr = r_clr_addr[PC_W-1:0];
            gc_wdata = GC_RST;
            lc_wdata = CTR_RST;
            lh_wdata = LH_RST;
        end else begin
            gc_we    = resolve_fire && r_func;
            lc_we    = resolve_fire && r_func;
            lh_we    = resolve_fire && r_func;
            gc_waddr = r_gidx;
            lc_waddr = lidx;
            lh_waddr = r_pidx;
            gc_wdata = {cctr_n, gctr_n};
            lc_wdata = lctr_n;
            lh_wdata = lhist_n;
        end
    end

    tbp_ram #(.WIDTH(GC_W), .DEPTH(GDEPTH)) u_gc_ram (
        .i_clk   (i_clk),
        .i_we    (gc_we),
        .i_waddr (gc_waddr),
        .i_wdata (gc_wdata),
        .i_re    (gc_re),
        .i_raddr (gc_raddr),
        .o_rdata (gc_rdata)
    );

    tbp_ram #(.WIDTH(CTR_W), .DEPTH(LDEPTH)) u_lc_ram (
        .i_clk   (i_clk),
        .i_we    (lc_we),
        .i_waddr (lc_waddr),
        .i_wdata (lc_wdata),
        .i_re    (lc_re),
        .i_raddr (lc_raddr),
        .o_rdata (lc_rdata)
    );

    tbp_ram #(.WIDTH(LHIST_W), .DEPTH(PDEPTH)) u_lh_ram (
        .i_clk   (i_clk),
        .i_we    (lh_we),
        .i_waddr (lh_waddr),
        .i_wdata (lh_wdata),
        .i_re    (lh_re),
        .i_raddr (lh_raddr),
        .o_rdata (lh_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (clr_last) n_state = S_IDLE;
            S_IDLE:    if (req_fire) n_state = S_LHIST;
            S_LHIST:   n_state = S_RESOLVE;
            S_RESOLVE: if (resolve_fire) n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_ghist     <= '0;
            r_out_valid <= 1'b0;
            r_ghb       <= GHB_RST;
            r_lhb       <= LHB_RST;
            r_pcb       <= PCB_RST;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + CLR_W'(1);
            end
            if (resolve_fire && r_func) begin
                r_ghist <= ghist_n;
            end
            if (resolve_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GHB: r_ghb <= i_cfg_data;
                    CFG_LHB: r_lhb <= i_cfg_data;
                    CFG_PCB: r_pcb <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Request payload and response data
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_func  <= i_req.func;
            r_taken <= i_req.taken;
            r_pidx  <= lh_raddr;
            r_gidx  <= gc_raddr;
        end
        if (resolve_fire) begin
            r_pred  <= pred;
            r_chose <= use_global;
        end
    end
endmodule

`default_nettype wire
